@@ hdl/rpc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rpc_pkg;

    localparam int RB_LEVELS = 8;
    localparam int G_LEVELS  = 4;
    localparam int RB_IDX_W  = $clog2(RB_LEVELS);
    localparam int G_IDX_W   = $clog2(G_LEVELS);

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    typedef enum logic {
        FUNC_COMPRESS = 1'b0,
        FUNC_EXPAND   = 1'b1
    } t_func;

    typedef logic [7:0] t_rb_table [RB_LEVELS];
    typedef logic [7:0] t_g_table [G_LEVELS];

    localparam t_rb_table RB_TABLE = '{8'h00, 8'h20, 8'h40, 8'h60, 8'hA0, 8'hC0, 8'hE0, 8'hFF};
    localparam t_g_table  G_TABLE  = '{8'h00, 8'h60, 8'hB0, 8'hFF};

    // The level tables are sorted, so the nearest index is the number of
    // midpoints the value lies strictly above. A value exactly on a midpoint
    // stays with the lower index.
    function automatic logic [RB_IDX_W-1:0] rb_index(input logic [7:0] val);
        logic [RB_IDX_W-1:0] idx;
        logic [8:0]          twice;
        logic [8:0]          mid_sum;
        idx   = '0;
        twice = {val, 1'b0};
        for (int i = 0; i < RB_LEVELS - 1; i++) begin
            mid_sum = {1'b0, RB_TABLE[i]} + {1'b0, RB_TABLE[i+1]};
            if (twice > mid_sum) begin
                idx = idx + 1'b1;
            end
        end
        return idx;
    endfunction

    function automatic logic [G_IDX_W-1:0] g_index(input logic [7:0] val);
        logic [G_IDX_W-1:0] idx;
        logic [8:0]         twice;
        logic [8:0]         mid_sum;
        idx   = '0;
        twice = {val, 1'b0};
        for (int i = 0; i < G_LEVELS - 1; i++) begin
            mid_sum = {1'b0, G_TABLE[i]} + {1'b0, G_TABLE[i+1]};
            if (twice > mid_sum) begin
                idx = idx + 1'b1;
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

@@ hdl/rgb_palette_pixel_codec.sv @@
// Pixel colour codec: quantizes 8-bit RGB to a packed RRRGGBBB byte against
// fixed non-uniform level tables, or expands a packed byte back to RGB with
// an opaque alpha. The x, y and z coordinates travel with the pixel.
//
// Input channel: i_valid with the pixel fields, o_stall back to the source.
// A request is taken at a rising edge with i_valid high and o_stall low.
// Output channel: o_valid with the result fields, i_stall from the sink.
// A result is delivered at a rising edge with o_valid high and i_stall low.
//
// There is an input register and a result register with a single pass of
// table compares between them, and one pixel is taken every cycle while the
// sink keeps up. When the sink stalls, the result register holds its value
// and the input register fills behind it; o_stall rises only when both are
// full and the result is not being taken. No pixel is dropped or repeated.
//
// Synchronous reset empties both registers. There is no other state.
`timescale 1ns / 1ps
`default_nettype none

module rgb_palette_pixel_codec (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_func,
    input  wire logic [15:0] i_coord_x,
    input  wire logic [15:0] i_coord_y,
    input  wire logic [15:0] i_coord_z,
    input  wire logic [7:0]  i_red_in,
    input  wire logic [7:0]  i_green_in,
    input  wire logic [7:0]  i_blue_in,
    input  wire logic [7:0]  i_packed_in,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic      [15:0] o_x_out,
    output logic      [15:0] o_y_out,
    output logic      [15:0] o_z_out,
    output logic      [7:0]  o_packed_out,
    output logic      [7:0]  o_red_out,
    output logic      [7:0]  o_green_out,
    output logic      [7:0]  o_blue_out,
    output logic      [7:0]  o_alpha_out
);
    import rpc_pkg::*;

    logic        r_in_valid;
    logic        r_func;
    logic [15:0] r_coord_x;
    logic [15:0] r_coord_y;
    logic [15:0] r_coord_z;
    logic [7:0]  r_red_in;
    logic [7:0]  r_green_in;
    logic [7:0]  r_blue_in;
    logic [7:0]  r_packed_in;

    logic        r_out_valid;
    logic [15:0] r_x_out;
    logic [15:0] r_y_out;
    logic [15:0] r_z_out;
    logic [7:0]  r_packed_out;
    logic [7:0]  r_red_out;
    logic [7:0]  r_green_out;
    logic [7:0]  r_blue_out;
    logic [7:0]  r_alpha_out;

    logic [7:0] q_packed;
    logic [7:0] q_red;
    logic [7:0] q_green;
    logic [7:0] q_blue;
    logic [7:0] q_alpha;

    logic out_free;
    logic in_free;
    logic in_take;
    logic n_in_valid;
    logic n_out_valid;

    rpc_quant u_quant (
        .i_func   (r_func),
        .i_red    (r_red_in),
        .i_green  (r_green_in),
        .i_blue   (r_blue_in),
        .i_packed (r_packed_in),
        .o_packed (q_packed),
        .o_red    (q_red),
        .o_green  (q_green),
        .o_blue   (q_blue),
        .o_alpha  (q_alpha)
    );

    // Each register advances when the one after it is empty or emptying.
    always_comb begin
        out_free    = !r_out_valid || !i_stall;
        in_free     = !r_in_valid || out_free;
        in_take     = i_valid && in_free;
        n_out_valid = out_free ? r_in_valid : r_out_valid;
        n_in_valid  = in_free ? i_valid : r_in_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_func      <= i_func;
            r_coord_x   <= i_coord_x;
            r_coord_y   <= i_coord_y;
            r_coord_z   <= i_coord_z;
            r_red_in    <= i_red_in;
            r_green_in  <= i_green_in;
            r_blue_in   <= i_blue_in;
            r_packed_in <= i_packed_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_in_valid) begin
            r_x_out      <= r_coord_x;
            r_y_out      <= r_coord_y;
            r_z_out      <= r_coord_z;
            r_packed_out <= q_packed;
            r_red_out    <= q_red;
            r_green_out  <= q_green;
            r_blue_out   <= q_blue;
            r_alpha_out  <= q_alpha;
        end
    end

    assign o_stall      = !in_free;
    assign o_valid      = r_out_valid;
    assign o_x_out      = r_x_out;
    assign o_y_out      = r_y_out;
    assign o_z_out      = r_z_out;
    assign o_packed_out = r_packed_out;
    assign o_red_out    = r_red_out;
    assign o_green_out  = r_green_out;
    assign o_blue_out   = r_blue_out;
    assign o_alpha_out  = r_alpha_out;

endmodule

`default_nettype wire

@@ hdl/rpc_quant.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rpc_quant (
    input  wire logic       i_func,
    input  wire logic [7:0] i_red,
    input  wire logic [7:0] i_green,
    input  wire logic [7:0] i_blue,
    input  wire logic [7:0] i_packed,
    output logic      [7:0] o_packed,
    output logic      [7:0] o_red,
    output logic      [7:0] o_green,
    output logic      [7:0] o_blue,
    output logic      [7:0] o_alpha
);
    import rpc_pkg::*;

    logic [RB_IDX_W-1:0] red_idx;
    logic [G_IDX_W-1:0]  green_idx;
    logic [RB_IDX_W-1:0] blue_idx;

    always_comb begin
        red_idx   = rb_index(i_red);
        green_idx = g_index(i_green);
        blue_idx  = rb_index(i_blue);

        if (i_func == FUNC_EXPAND) begin
            o_packed = '0;
            o_red    = RB_TABLE[i_packed[7:5]];
            o_green  = G_TABLE[i_packed[4:3]];
            o_blue   = RB_TABLE[i_packed[2:0]];
            o_alpha  = ALPHA_OPAQUE;
        end else begin
            o_packed = {red_idx, green_idx, blue_idx};
            o_red    = '0;
            o_green  = '0;
            o_blue   = '0;
            o_alpha  = '0;
        end
    end

endmodule

`default_nettype wire

@@ verif/pixel_codec_checker.sv @@
`timescale 1ns / 1ps

module pixel_codec_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_req_valid,
    input  wire logic        i_req_stall,
    input  wire logic        i_func,
    input  wire logic [15:0] i_coord_x,
    input  wire logic [15:0] i_coord_y,
    input  wire logic [15:0] i_coord_z,
    input  wire logic [7:0]  i_red,
    input  wire logic [7:0]  i_green,
    input  wire logic [7:0]  i_blue,
    input  wire logic [7:0]  i_code,
    input  wire logic        i_rsp_valid,
    input  wire logic        i_rsp_stall,
    input  wire logic [15:0] i_x_out,
    input  wire logic [15:0] i_y_out,
    input  wire logic [15:0] i_z_out,
    input  wire logic [7:0]  i_code_out,
    input  wire logic [7:0]  i_red_out,
    input  wire logic [7:0]  i_green_out,
    input  wire logic [7:0]  i_blue_out,
    input  wire logic [7:0]  i_alpha_out,
    output int               o_mismatches,
    output int               o_pending
);
    import rpc_pkg::*;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
        logic [7:0]  code;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
    } t_pixel_result;

    t_pixel_result expected_pixels[$];
    int            mismatch_total = 0;

    assign o_mismatches = mismatch_total;

    // Smallest absolute distance to a level wins; a strict compare keeps the
    // lower index when two levels are equally close.
    function automatic int unsigned nearest_level_index(logic [7:0] val, bit use_green);
        int unsigned best_idx;
        int unsigned best_diff;
        int unsigned lvl;
        int unsigned diff;
        int unsigned count;
        best_idx  = 0;
        best_diff = 256;
        count     = use_green ? G_LEVELS : RB_LEVELS;
        for (int i = 0; i < count; i++) begin
            if (use_green) begin
                lvl = G_TABLE[i];
            end else begin
                lvl = RB_TABLE[i];
            end
            diff = (val >= lvl) ? (val - lvl) : (lvl - val);
            if (diff < best_diff) begin
                best_diff = diff;
                best_idx  = i;
            end
        end
        return best_idx;
    endfunction

    function automatic t_pixel_result codec_pixel(t_func func, logic [15:0] x, logic [15:0] y,
                                                  logic [15:0] z, logic [7:0] r, logic [7:0] g,
                                                  logic [7:0] b, logic [7:0] code);
        t_pixel_result res;
        logic [2:0]    r_idx;
        logic [1:0]    g_idx;
        logic [2:0]    b_idx;
        res   = '0;
        res.x = x;
        res.y = y;
        res.z = z;
        if (func == FUNC_COMPRESS) begin
            r_idx    = 3'(nearest_level_index(r, 1'b0));
            g_idx    = 2'(nearest_level_index(g, 1'b1));
            b_idx    = 3'(nearest_level_index(b, 1'b0));
            res.code = {r_idx, g_idx, b_idx};
        end else begin
            res.red   = RB_TABLE[code[7:5]];
            res.green = G_TABLE[code[4:3]];
            res.blue  = RB_TABLE[code[2:0]];
            res.alpha = ALPHA_OPAQUE;
        end
        return res;
    endfunction

    task automatic check_field(string label, int unsigned want, int unsigned got);
        if (want != got) begin
            mismatch_total++;
            $display("%0t: %s expected %0h, got %0h", $time, label, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_pixel_result want;
        if (!i_rst_n) begin
            expected_pixels.delete();
        end else begin
            if (i_req_valid && !i_req_stall) begin
                expected_pixels.push_back(codec_pixel(t_func'(i_func), i_coord_x, i_coord_y,
                                                      i_coord_z, i_red, i_green, i_blue,
                                                      i_code));
            end
            if (i_rsp_valid && !i_rsp_stall) begin
                if (expected_pixels.size() == 0) begin
                    mismatch_total++;
                    $display("%0t: result delivered with no request outstanding", $time);
                end else begin
                    want = expected_pixels.pop_front();
                    check_field("x_out", want.x, i_x_out);
                    check_field("y_out", want.y, i_y_out);
                    check_field("z_out", want.z, i_z_out);
                    check_field("packed_out", want.code, i_code_out);
                    check_field("red_out", want.red, i_red_out);
                    check_field("green_out", want.green, i_green_out);
                    check_field("blue_out", want.blue, i_blue_out);
                    check_field("alpha_out", want.alpha, i_alpha_out);
                end
            end
        end
        o_pending <= expected_pixels.size();
    end

endmodule

@@ verif/rgb_palette_pixel_codec_tb.sv @@
`timescale 1ns / 1ps

module rgb_palette_pixel_codec_tb;
    import rpc_pkg::*;

    localparam int RANDOM_PIXELS    = 1700;
    localparam int SINK_HOLD_CYCLES = 64;

    // Channel values on and around the points where two levels are equally close.
    localparam logic [7:0] RB_EDGES [12] = '{8'h00, 8'h10, 8'h11, 8'h30, 8'h50, 8'h80,
                                             8'h81, 8'hB0, 8'hD0, 8'hEF, 8'hF0, 8'hFF};
    localparam logic [7:0] G_EDGES [8] = '{8'h00, 8'h30, 8'h31, 8'h88, 8'h89, 8'hD7,
                                           8'hD8, 8'hFF};
    localparam logic [15:0] COORD_EDGES [4] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
    localparam logic [7:0] CODE_EDGES [8] = '{8'h00, 8'hFF, 8'hE0, 8'h18, 8'h07, 8'hAA,
                                              8'h55, 8'h6D};

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    t_func       i_func;
    logic [15:0] i_coord_x;
    logic [15:0] i_coord_y;
    logic [15:0] i_coord_z;
    logic [7:0]  i_red_in;
    logic [7:0]  i_green_in;
    logic [7:0]  i_blue_in;
    logic [7:0]  i_packed_in;
    logic        o_valid;
    logic        i_stall;
    logic [15:0] o_x_out;
    logic [15:0] o_y_out;
    logic [15:0] o_z_out;
    logic [7:0]  o_packed_out;
    logic [7:0]  o_red_out;
    logic [7:0]  o_green_out;
    logic [7:0]  o_blue_out;
    logic [7:0]  o_alpha_out;

    int mismatches;
    int pending;
    bit steady_flow = 1'b0;
    bit sink_hold_req = 1'b0;

    rgb_palette_pixel_codec u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_func       (i_func),
        .i_coord_x    (i_coord_x),
        .i_coord_y    (i_coord_y),
        .i_coord_z    (i_coord_z),
        .i_red_in     (i_red_in),
        .i_green_in   (i_green_in),
        .i_blue_in    (i_blue_in),
        .i_packed_in  (i_packed_in),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_x_out      (o_x_out),
        .o_y_out      (o_y_out),
        .o_z_out      (o_z_out),
        .o_packed_out (o_packed_out),
        .o_red_out    (o_red_out),
        .o_green_out  (o_green_out),
        .o_blue_out   (o_blue_out),
        .o_alpha_out  (o_alpha_out)
    );

    pixel_codec_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_valid),
        .i_req_stall  (o_stall),
        .i_func       (i_func),
        .i_coord_x    (i_coord_x),
        .i_coord_y    (i_coord_y),
        .i_coord_z    (i_coord_z),
        .i_red        (i_red_in),
        .i_green      (i_green_in),
        .i_blue       (i_blue_in),
        .i_code       (i_packed_in),
        .i_rsp_valid  (o_valid),
        .i_rsp_stall  (i_stall),
        .i_x_out      (o_x_out),
        .i_y_out      (o_y_out),
        .i_z_out      (o_z_out),
        .i_code_out   (o_packed_out),
        .i_red_out    (o_red_out),
        .i_green_out  (o_green_out),
        .i_blue_out   (o_blue_out),
        .i_alpha_out  (o_alpha_out),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #200000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Sink side: random stalls, a quiet stretch, and one long hold-off on request.
    initial begin
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (sink_hold_req) begin
                i_stall <= 1'b1;
                repeat (SINK_HOLD_CYCLES - 1) @(posedge i_clk);
                sink_hold_req = 1'b0;
            end else if (steady_flow) begin
                i_stall <= 1'b0;
            end else begin
                i_stall <= ($urandom_range(99) < 27);
            end
        end
    end

    // Presents one request and returns at the edge where it is taken.
    task automatic offer_pixel(t_func func, logic [15:0] x, logic [15:0] y, logic [15:0] z,
                               logic [7:0] r, logic [7:0] g, logic [7:0] b,
                               logic [7:0] code);
        if (!steady_flow && $urandom_range(99) < 27) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_func      <= func;
        i_coord_x   <= x;
        i_coord_y   <= y;
        i_coord_z   <= z;
        i_red_in    <= r;
        i_green_in  <= g;
        i_blue_in   <= b;
        i_packed_in <= code;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Mostly uniform, with a share of values placed near the level boundaries.
    function automatic logic [7:0] pick_channel(bit use_green);
        if ($urandom_range(99) < 70) begin
            return 8'($urandom);
        end else if (use_green) begin
            return G_EDGES[$urandom_range(7)];
        end else begin
            return RB_EDGES[$urandom_range(11)];
        end
    endfunction

    // The pending count is registered behind the channel, so it is read only once
    // the last request is in the checker's queue.
    task automatic wait_for_results();
        i_valid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_func      = FUNC_COMPRESS;
        i_coord_x   = '0;
        i_coord_y   = '0;
        i_coord_z   = '0;
        i_red_in    = '0;
        i_green_in  = '0;
        i_blue_in   = '0;
        i_packed_in = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Compress across the tie points and the channel extremes; the unused
        // packed byte carries junk.
        for (int i = 0; i < 12; i++) begin
            offer_pixel(FUNC_COMPRESS, COORD_EDGES[i % 4], COORD_EDGES[(i + 1) % 4],
                        COORD_EDGES[(i + 2) % 4], RB_EDGES[i], G_EDGES[i % 8],
                        RB_EDGES[11 - i], 8'($urandom));
        end
        // Expand with every field of the packed byte at its extremes.
        for (int i = 0; i < 8; i++) begin
            offer_pixel(FUNC_EXPAND, COORD_EDGES[(i + 3) % 4], COORD_EDGES[i % 4],
                        COORD_EDGES[(i + 1) % 4], 8'($urandom), 8'($urandom),
                        8'($urandom), CODE_EDGES[i]);
        end
        wait_for_results();

        for (int n = 0; n < RANDOM_PIXELS; n++) begin
            if (n == 500) begin
                sink_hold_req = 1'b1;
            end
            steady_flow = (n >= 900 && n < 1200);
            offer_pixel(t_func'($urandom_range(1)), 16'($urandom), 16'($urandom),
                        16'($urandom), pick_channel(1'b0), pick_channel(1'b1),
                        pick_channel(1'b0), 8'($urandom));
        end
        steady_flow = 1'b0;
        wait_for_results();

        if (mismatches == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
